### hw/rtl/crtp_pkg.sv
// Shared types, constants and arctangent table for the cartesian to polar converter.
package crtp_pkg;

	localparam int DATA_WIDTH   = 64;
	localparam int ACC_WIDTH    = 32;
	localparam int ANGLE_WIDTH  = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int NORM_MSB     = 60;

	localparam logic [ACC_WIDTH-1:0] HALF_TURN = 32'h8000_0000;

	localparam logic [ACC_WIDTH-1:0] ARC_TABLE [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef enum logic [1:0] {
		QUAD_POS_X = 2'd0,
		QUAD_POS_Y = 2'd1,
		QUAD_NEG_X = 2'd2,
		QUAD_NEG_Y = 2'd3
	} quad_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] x;
		logic signed [DATA_WIDTH-1:0] y;
		logic [ACC_WIDTH-1:0]         acc;
		logic                         axis;
		quad_t                        quad;
	} vec_t;

endpackage

### hw/rtl/cartesian_to_polar_top.sv
// Top level of the cartesian to polar converter: front end, cell chains and output register.
//
// Converts a signed point (x_coord, y_coord) to its rounded radius and a
// four-quadrant binary angle (65536 per turn, +pi reads as -32768).
// Command channel: a beat is taken at a rising edge with start high and
// busy low. busy is high during reset and until the first rising edge after
// release, low from then on, so one point can be issued every clock.
// Result channel: done is high for exactly one cycle with radius and angle;
// the receiver must take it then, there is no stall.
// When done rises is set by the longer of two chains: the square root
// (one cell per result bit after a squaring and a summing stage) and the
// angle path (one normalizer stage per shift weight, then one rotation
// cell per step); a delay line pads the shorter chain to match.
// Throughput: one point per clock.
// Reset drops every beat in flight; no state survives between points.
module cartesian_to_polar_top #(
	parameter int COORD_WIDTH    = 16,
	parameter int ROTATION_STEPS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_WIDTH-1:0]       x_coord,
	input  logic signed [COORD_WIDTH-1:0]       y_coord,
	output logic                                done,
	output logic [COORD_WIDTH-1:0]              radius,
	output logic signed [crtp_pkg::ANGLE_WIDTH-1:0] angle
);

	localparam int W    = COORD_WIDTH;
	localparam int R    = ROTATION_STEPS;
	localparam int N    = $clog2(W);
	localparam int RW   = W + 2;
	localparam int DW   = crtp_pkg::DATA_WIDTH;
	localparam int AW   = crtp_pkg::ANGLE_WIDTH;
	localparam int BASE = crtp_pkg::NORM_MSB + 1 - W;
	localparam int RL   = W + 3;
	localparam int AL   = N + R + 2;
	localparam int LAT  = (RL > AL) ? RL : AL;
	localparam int PR   = LAT - RL;
	localparam int PA   = LAT - AL;
	localparam int VW   = $bits(crtp_pkg::vec_t);

	logic           busy_q;
	logic           accept;
	logic [LAT-1:0] valid_q;

	logic signed [W-1:0] x_s1;
	logic signed [W-1:0] y_s1;

	// magnitude branch
	logic [W-1:0]   ax;
	logic [W-1:0]   ay;
	logic [2*W-1:0] sqx_s2;
	logic [2*W-1:0] sqy_s2;
	logic [2*W-1:0] sum_s3;
	logic [2*W-1:0] rad_c [W+1];
	logic [RW-1:0]  rem_c [W+1];
	logic [W-1:0]   root_c [W+1];
	logic [RW+W-1:0] root_end;

	// angle branch
	logic signed [DW-1:0] xw;
	logic signed [DW-1:0] yw;
	logic signed [DW-1:0] hx;
	logic signed [DW-1:0] hy;
	logic [W-1:0]         mx;
	logic [W-1:0]         my;
	logic                 flip;
	crtp_pkg::vec_t       prep;
	crtp_pkg::vec_t       vec_s2;
	logic [W-1:0]         big_s2;
	crtp_pkg::vec_t       vec_n [N+1];
	logic [W-1:0]         big_n [N+1];
	crtp_pkg::vec_t       vec_r [R+1];
	logic [VW-1:0]        vec_end_bits;
	crtp_pkg::vec_t       vec_end;

	logic [RW-1:0]        rem_end;
	logic [W-1:0]         root_fin;

	logic                 done_q;
	logic [W-1:0]         radius_q;
	logic [AW-1:0]        angle_q;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			busy_q  <= 1'b0;
			valid_q <= {valid_q[LAT-2:0], accept};
			done_q  <= valid_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= x_coord;
		y_s1 <= y_coord;
	end

	// magnitude: square, sum, then one root cell per result bit
	always_comb begin
		ax = x_s1[W-1] ? (~x_s1 + 1'b1) : x_s1;
		ay = y_s1[W-1] ? (~y_s1 + 1'b1) : y_s1;
	end

	always_ff @(posedge clk) begin
		sqx_s2 <= (2*W)'(ax) * (2*W)'(ax);
		sqy_s2 <= (2*W)'(ay) * (2*W)'(ay);
		sum_s3 <= sqx_s2 + sqy_s2;
	end

	assign rad_c[0]  = sum_s3;
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar k = 0; k < W; k++) begin : g_root
		crtp_root_cell #(
			.W(W)
		) u_cell (
			.clk       (clk),
			.prev_rad  (rad_c[k]),
			.prev_rem  (rem_c[k]),
			.prev_root (root_c[k]),
			.next_rad  (rad_c[k+1]),
			.next_rem  (rem_c[k+1]),
			.next_root (root_c[k+1])
		);
	end

	if (PR > 0) begin : g_root_pad
		crtp_delay #(
			.WIDTH(RW + W),
			.DEPTH(PR)
		) u_pad (
			.clk  (clk),
			.prev ({rem_c[W], root_c[W]}),
			.next (root_end)
		);
	end else begin : g_root_nopad
		assign root_end = {rem_c[W], root_c[W]};
	end

	// angle: half-turn fold, axis detection, coarse placement
	always_comb begin
		xw   = DW'(x_s1);
		yw   = DW'(y_s1);
		flip = x_s1[W-1];
		hx   = flip ? -xw : xw;
		hy   = flip ? -yw : yw;
		mx   = W'(hx);
		my   = hy[DW-1] ? W'(-hy) : W'(hy);
		prep.x    = hx << BASE;
		prep.y    = hy << BASE;
		prep.acc  = flip ? crtp_pkg::HALF_TURN : '0;
		prep.axis = (y_s1 == '0) || (x_s1 == '0);
		if (y_s1 == '0) begin
			prep.quad = flip ? crtp_pkg::QUAD_NEG_X : crtp_pkg::QUAD_POS_X;
		end else begin
			prep.quad = y_s1[W-1] ? crtp_pkg::QUAD_NEG_Y : crtp_pkg::QUAD_POS_Y;
		end
	end

	always_ff @(posedge clk) begin
		vec_s2 <= prep;
		big_s2 <= (mx > my) ? mx : my;
	end

	assign vec_n[0] = vec_s2;
	assign big_n[0] = big_s2;

	for (genvar j = 0; j < N; j++) begin : g_norm
		crtp_norm_cell #(
			.W     (W),
			.SHIFT (1 << (N - 1 - j))
		) u_cell (
			.clk      (clk),
			.prev_vec (vec_n[j]),
			.prev_big (big_n[j]),
			.next_vec (vec_n[j+1]),
			.next_big (big_n[j+1])
		);
	end

	assign vec_r[0] = vec_n[N];

	for (genvar i = 0; i < R; i++) begin : g_rot
		crtp_rot_cell #(
			.STEP(i)
		) u_cell (
			.clk      (clk),
			.prev_vec (vec_r[i]),
			.next_vec (vec_r[i+1])
		);
	end

	if (PA > 0) begin : g_angle_pad
		crtp_delay #(
			.WIDTH(VW),
			.DEPTH(PA)
		) u_pad (
			.clk  (clk),
			.prev (vec_r[R]),
			.next (vec_end_bits)
		);
	end else begin : g_angle_nopad
		assign vec_end_bits = vec_r[R];
	end

	assign vec_end  = crtp_pkg::vec_t'(vec_end_bits);
	assign rem_end  = root_end[RW+W-1:W];
	assign root_fin = root_end[W-1:0];

	// round half up on both results
	always_ff @(posedge clk) begin
		radius_q <= root_fin + W'(rem_end > RW'(root_fin));
		if (vec_end.axis) begin
			angle_q <= {vec_end.quad, {(AW-2){1'b0}}};
		end else begin
			angle_q <= vec_end.acc[crtp_pkg::ACC_WIDTH-1 -: AW]
				+ AW'(vec_end.acc[crtp_pkg::ACC_WIDTH-AW-1]);
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign radius = radius_q;
	assign angle  = angle_q;

`ifndef ASSERT_OFF
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(LAT+1) done)
		else $error("accepted beat did not complete after the pipeline latency");

	a_no_spurious : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT+1))
		else $error("result beat without a matching command beat");

	a_origin : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && x_coord == '0 && y_coord == '0)
		|-> ##(LAT+1) (radius == '0 && angle == '0))
		else $error("origin must give zero radius and zero angle");

	a_pos_x_axis : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && y_coord == '0 && !x_coord[W-1])
		|-> ##(LAT+1) (angle == '0 && radius == $unsigned($past(x_coord, LAT+1))))
		else $error("positive x axis must give zero angle and radius equal to x");
`endif

endmodule

### hw/rtl/crtp_root_cell.sv
// One digit cell of the pipelined integer square root.
module crtp_root_cell #(
	parameter int W = 16
) (
	input  logic             clk,
	input  logic [2*W-1:0]   prev_rad,
	input  logic [W+1:0]     prev_rem,
	input  logic [W-1:0]     prev_root,
	output logic [2*W-1:0]   next_rad,
	output logic [W+1:0]     next_rem,
	output logic [W-1:0]     next_root
);

	localparam int RW = W + 2;

	logic [RW+1:0]  cand;
	logic [RW+1:0]  trial;
	logic           fit;
	logic [2*W-1:0] rad_q;
	logic [RW-1:0]  rem_q;
	logic [W-1:0]   root_q;

	always_comb begin
		cand  = {prev_rem, prev_rad[2*W-1 -: 2]};
		trial = (RW+2)'({prev_root, 2'b01});
		fit   = (cand >= trial);
	end

	always_ff @(posedge clk) begin
		rad_q <= prev_rad << 2;
		if (fit) begin
			rem_q  <= RW'(cand - trial);
			root_q <= {prev_root[W-2:0], 1'b1};
		end else begin
			rem_q  <= RW'(cand);
			root_q <= {prev_root[W-2:0], 1'b0};
		end
	end

	assign next_rad  = rad_q;
	assign next_rem  = rem_q;
	assign next_root = root_q;

endmodule

### hw/rtl/crtp_norm_cell.sv
// One binary-weighted stage of the leading-one normalizer ahead of the rotation chain.
module crtp_norm_cell #(
	parameter int W     = 16,
	parameter int SHIFT = 8
) (
	input  logic            clk,
	input  crtp_pkg::vec_t  prev_vec,
	input  logic [W-1:0]    prev_big,
	output crtp_pkg::vec_t  next_vec,
	output logic [W-1:0]    next_big
);

	crtp_pkg::vec_t vec_d;
	logic [W-1:0]   big_d;
	crtp_pkg::vec_t vec_q;
	logic [W-1:0]   big_q;

	always_comb begin
		vec_d = prev_vec;
		big_d = prev_big;
		if (prev_big[W-1 -: SHIFT] == '0) begin
			vec_d.x = prev_vec.x << SHIFT;
			vec_d.y = prev_vec.y << SHIFT;
			big_d   = prev_big << SHIFT;
		end
	end

	always_ff @(posedge clk) begin
		vec_q <= vec_d;
		big_q <= big_d;
	end

	assign next_vec = vec_q;
	assign next_big = big_q;

endmodule

### hw/rtl/crtp_rot_cell.sv
// One vectoring micro-rotation cell of the CORDIC angle chain.
module crtp_rot_cell #(
	parameter int STEP = 0
) (
	input  logic            clk,
	input  crtp_pkg::vec_t  prev_vec,
	output crtp_pkg::vec_t  next_vec
);

	logic signed [crtp_pkg::DATA_WIDTH-1:0] px;
	logic signed [crtp_pkg::DATA_WIDTH-1:0] py;
	logic signed [crtp_pkg::DATA_WIDTH-1:0] dx;
	logic signed [crtp_pkg::DATA_WIDTH-1:0] dy;
	crtp_pkg::vec_t vec_d;
	crtp_pkg::vec_t vec_q;

	always_comb begin
		px    = prev_vec.x;
		py    = prev_vec.y;
		dx    = py >>> STEP;
		dy    = px >>> STEP;
		vec_d = prev_vec;
		if (!py[crtp_pkg::DATA_WIDTH-1]) begin
			vec_d.x   = px + dx;
			vec_d.y   = py - dy;
			vec_d.acc = prev_vec.acc + crtp_pkg::ARC_TABLE[STEP];
		end else begin
			vec_d.x   = px - dx;
			vec_d.y   = py + dy;
			vec_d.acc = prev_vec.acc - crtp_pkg::ARC_TABLE[STEP];
		end
	end

	always_ff @(posedge clk) begin
		vec_q <= vec_d;
	end

	assign next_vec = vec_q;

endmodule

### hw/rtl/crtp_delay.sv
// Fixed-depth shift line that balances the two branches of the pipeline.
module crtp_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] prev,
	output logic [WIDTH-1:0] next
);

	logic [WIDTH-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		line_q[0] <= prev;
		for (int i = 1; i < DEPTH; i++) begin
			line_q[i] <= line_q[i-1];
		end
	end

	assign next = line_q[DEPTH-1];

endmodule
